FILE: sv/color_ramp_table_generator_macros.svh
// Assertion helpers used by the checker of this block.
`ifndef COLOR_RAMP_TABLE_GENERATOR_MACROS_SVH
`define COLOR_RAMP_TABLE_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define CRTG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crtg assertion failed");

// Next-cycle implication, disabled while reset is low.
`define CRTG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crtg assertion failed");

`endif

FILE: sv/crtg_pkg.sv
`timescale 1ns / 1ps

package crtg_pkg;

  localparam int KEY_W   = 16;
  localparam int COLOR_W = 24;
  localparam int CHAN_W  = 8;
  localparam int V_W     = 28;
  localparam int D_W     = 27;
  localparam int T_W     = 35;
  localparam int N_W     = 36;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_RAMP   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FEW   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic signed [KEY_W-1:0] val;
    logic [COLOR_W-1:0]      color;
  } crtg_key_t;

  typedef struct packed {
    logic      insert;
    logic      rotate;
    crtg_key_t key;
  } crtg_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_V2,
    S_SCAN,
    S_LO,
    S_PREP,
    S_MA,
    S_MB,
    S_DIV,
    S_DONE
  } crtg_state_t;

  function automatic logic [CHAN_W-1:0] chan_of(input logic [COLOR_W-1:0] color,
                                               input logic [1:0] ch);
    logic [CHAN_W-1:0] c;
    case (ch)
      2'd0:    c = color[23:16];
      2'd1:    c = color[15:8];
      default: c = color[7:0];
    endcase
    return c;
  endfunction

endpackage

FILE: sv/crtg_key_stage.sv
`timescale 1ns / 1ps

module crtg_key_stage (
  input  logic                 clk,
  input  crtg_pkg::crtg_cmd_t  cmd,
  input  logic                 occupied,
  input  logic                 at_tail,
  input  logic                 prev_gt,
  input  crtg_pkg::crtg_key_t  prev_key,
  input  crtg_pkg::crtg_key_t  next_key,
  output logic                 gt,
  output crtg_pkg::crtg_key_t  key
);

  crtg_pkg::crtg_key_t key_r;
  crtg_pkg::crtg_key_t key_nxt;

  assign gt  = occupied && (key_r.val > cmd.key.val);
  assign key = key_r;

  always_comb begin
    key_nxt = key_r;
    if (cmd.rotate) begin
      key_nxt = next_key;
    end else if (cmd.insert) begin
      if (prev_gt) begin
        key_nxt = prev_key;
      end else if (gt || at_tail) begin
        key_nxt = cmd.key;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

FILE: sv/color_ramp_table_generator.sv
`timescale 1ns / 1ps
// Clear, insert, unused modes and a refused ramp entry: strobe in the cycle after the start beat;
// busy stays low. Ramp entry: busy through V2, SCAN, LO, PREP, per-channel MA, MB, DIV, and DONE
// (zero width: PREP to DONE); strobe on the cycle busy drops; uses one key chain rotation and an
// 8-step divider per channel. Starts wait for busy low; one table edit per cycle while idle.
// Synchronous active-low reset empties the table, sets ramp_entries to 256 and goes idle.

module color_ramp_table_generator #(
  parameter int MAX_KEYS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic signed [15:0] in_key_value,
  input  logic [7:0]  in_key_red,
  input  logic [7:0]  in_key_green,
  input  logic [7:0]  in_key_blue,
  input  logic [7:0]  in_entry_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_ramp_entries,
  output logic        out_valid,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_index,
  output logic [1:0]  out_status
);

  localparam int CNT_W  = $clog2(MAX_KEYS + 1);
  localparam int STEP_W = $clog2(MAX_KEYS);

  crtg_pkg::crtg_state_t state_r, state_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [8:0]        ramp_r;
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [23:0]       out_rgb_r;
  logic [7:0]        out_index_r;

  logic signed [crtg_pkg::KEY_W-1:0] first_r, last_r, k0_r;
  logic signed [26:0]                p1_r;
  logic [24:0]                       p2_r;
  logic signed [crtg_pkg::V_W-1:0]   v2_r, hi_r, lo_r;
  logic [STEP_W-1:0]                 step_r;
  logic                              found_r;
  logic [crtg_pkg::COLOR_W-1:0]      c0_r, c1_r, rgb_r;
  logic [7:0]                        idx_r;
  logic [crtg_pkg::D_W-1:0]          a_r, b_r, den_r;
  logic [crtg_pkg::T_W-1:0]          t_r;
  logic [crtg_pkg::N_W-1:0]          rem_r, dsh_r;
  logic [7:0]                        q_r;
  logic [2:0]                        bit_r;
  logic [1:0]                        ch_r;

  crtg_pkg::crtg_cmd_t  cmd;
  crtg_pkg::crtg_key_t  keys [MAX_KEYS];
  logic                 gt_w [MAX_KEYS];

  logic                 acc, can_insert, hit, ge, zero_w, last_bit;
  logic signed [10:0]   n2_s;
  logic signed [crtg_pkg::KEY_W-1:0] mul_x;
  logic signed [26:0]   mul_w;
  logic [15:0]          span_w;
  logic [24:0]          p2_w;
  logic [7:0]           c0_ch, c1_ch, q_fin;
  logic [crtg_pkg::T_W-1:0] t_w, u_w;
  logic [crtg_pkg::N_W-1:0] num_w;

  assign busy       = (state_r != crtg_pkg::S_IDLE);
  assign cfg_ready  = !busy && !start;
  assign acc        = start && !busy;
  assign can_insert = (count_r < CNT_W'(MAX_KEYS));

  assign cmd.insert    = acc && (in_mode == crtg_pkg::MODE_INSERT) && can_insert;
  assign cmd.rotate    = (state_r == crtg_pkg::S_SCAN);
  assign cmd.key.val   = in_key_value;
  assign cmd.key.color = {in_key_red, in_key_green, in_key_blue};

  for (genvar g = 0; g < MAX_KEYS; g++) begin : g_chain
    if (g == 0) begin : g_head
      crtg_key_stage u_stage (
        .clk      (clk),
        .cmd      (cmd),
        .occupied (CNT_W'(g) < count_r),
        .at_tail  (CNT_W'(g) == count_r),
        .prev_gt  (1'b0),
        .prev_key (keys[MAX_KEYS-1]),
        .next_key (keys[1]),
        .gt       (gt_w[g]),
        .key      (keys[g])
      );
    end else begin : g_body
      crtg_key_stage u_stage (
        .clk      (clk),
        .cmd      (cmd),
        .occupied (CNT_W'(g) < count_r),
        .at_tail  (CNT_W'(g) == count_r),
        .prev_gt  (gt_w[g-1]),
        .prev_key (keys[g-1]),
        .next_key (keys[(g + 1) % MAX_KEYS]),
        .gt       (gt_w[g]),
        .key      (keys[g])
      );
    end
  end

  // one shared key * 2N multiplier
  assign n2_s = signed'({1'b0, ramp_r, 1'b0});
  always_comb begin
    case (state_r)
      crtg_pkg::S_IDLE: mul_x = first_r;
      crtg_pkg::S_LO:   mul_x = k0_r;
      default:          mul_x = keys[1].val;
    endcase
  end
  assign mul_w  = mul_x * n2_s;
  assign span_w = 16'(last_r - first_r);
  assign p2_w   = span_w * {in_entry_index, 1'b1};

  assign hit = !found_r && ((CNT_W'(step_r) + CNT_W'(1)) < count_r)
               && (v2_r <= crtg_pkg::V_W'(mul_w));

  assign zero_w   = (hi_r == lo_r);
  assign c0_ch    = crtg_pkg::chan_of(c0_r, ch_r);
  assign c1_ch    = crtg_pkg::chan_of(c1_r, ch_r);
  assign t_w      = c0_ch * a_r;
  assign u_w      = c1_ch * b_r;
  assign num_w    = crtg_pkg::N_W'(t_r) + crtg_pkg::N_W'(u_w);
  assign ge       = (rem_r >= dsh_r);
  assign q_fin    = {q_r[6:0], ge};
  assign last_bit = (bit_r == 3'd7);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      crtg_pkg::S_IDLE: begin
        if (acc && (in_mode == crtg_pkg::MODE_RAMP) && (count_r >= CNT_W'(2))
            && ({1'b0, in_entry_index} < ramp_r)) begin
          state_nxt = crtg_pkg::S_V2;
        end
      end
      crtg_pkg::S_V2:   state_nxt = crtg_pkg::S_SCAN;
      crtg_pkg::S_SCAN: begin
        if (step_r == STEP_W'(MAX_KEYS - 1)) begin
          state_nxt = crtg_pkg::S_LO;
        end
      end
      crtg_pkg::S_LO:   state_nxt = crtg_pkg::S_PREP;
      crtg_pkg::S_PREP: state_nxt = zero_w ? crtg_pkg::S_DONE : crtg_pkg::S_MA;
      crtg_pkg::S_MA:   state_nxt = crtg_pkg::S_MB;
      crtg_pkg::S_MB:   state_nxt = crtg_pkg::S_DIV;
      crtg_pkg::S_DIV: begin
        if (last_bit) begin
          state_nxt = (ch_r == 2'd2) ? crtg_pkg::S_DONE : crtg_pkg::S_MA;
        end
      end
      crtg_pkg::S_DONE: state_nxt = crtg_pkg::S_IDLE;
      default:          state_nxt = crtg_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= crtg_pkg::S_IDLE;
      count_r     <= '0;
      ramp_r      <= 9'd256;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        ramp_r <= cfg_ramp_entries;
      end
      if (acc) begin
        if (in_mode == crtg_pkg::MODE_CLEAR) begin
          count_r <= '0;
        end else if (cmd.insert) begin
          count_r <= count_r + CNT_W'(1);
        end
        if (state_nxt == crtg_pkg::S_IDLE) begin
          out_valid_r <= 1'b1;
        end
      end
      if (state_r == crtg_pkg::S_DONE) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (count_r == '0) begin
        first_r <= in_key_value;
        last_r  <= in_key_value;
      end else begin
        if (in_key_value < first_r) first_r <= in_key_value;
        if (in_key_value > last_r)  last_r  <= in_key_value;
      end
    end
    case (state_r)
      crtg_pkg::S_IDLE: begin
        p1_r         <= mul_w;
        p2_r         <= p2_w;
        idx_r        <= in_entry_index;
        out_rgb_r    <= '0;
        out_index_r  <= '0;
        out_status_r <= crtg_pkg::ST_OK;
        if (in_mode == crtg_pkg::MODE_INSERT && !can_insert) begin
          out_status_r <= crtg_pkg::ST_FULL;
        end else if (in_mode == crtg_pkg::MODE_RAMP) begin
          if (count_r < CNT_W'(2)) begin
            out_status_r <= crtg_pkg::ST_FEW;
          end else if ({1'b0, in_entry_index} >= ramp_r) begin
            out_status_r <= crtg_pkg::ST_RANGE;
          end
        end
      end
      crtg_pkg::S_V2: begin
        v2_r    <= crtg_pkg::V_W'(p1_r) + signed'({3'b000, p2_r});
        step_r  <= '0;
        found_r <= 1'b0;
      end
      crtg_pkg::S_SCAN: begin
        step_r <= step_r + STEP_W'(1);
        if (hit) begin
          found_r <= 1'b1;
          k0_r    <= keys[0].val;
          c0_r    <= keys[0].color;
          c1_r    <= keys[1].color;
          hi_r    <= crtg_pkg::V_W'(mul_w);
        end
      end
      crtg_pkg::S_LO: begin
        lo_r <= crtg_pkg::V_W'(mul_w);
      end
      crtg_pkg::S_PREP: begin
        den_r <= crtg_pkg::D_W'(hi_r - lo_r);
        a_r   <= crtg_pkg::D_W'(hi_r - v2_r);
        b_r   <= crtg_pkg::D_W'(v2_r - lo_r);
        ch_r  <= 2'd0;
        rgb_r <= c0_r;
      end
      crtg_pkg::S_MA: begin
        t_r <= t_w;
      end
      crtg_pkg::S_MB: begin
        rem_r <= {num_w[crtg_pkg::N_W-2:0], 1'b0} + crtg_pkg::N_W'(den_r);
        dsh_r <= {1'b0, den_r, 8'd0};
        q_r   <= '0;
        bit_r <= '0;
      end
      crtg_pkg::S_DIV: begin
        if (ge) rem_r <= rem_r - dsh_r;
        dsh_r <= dsh_r >> 1;
        q_r   <= q_fin;
        bit_r <= bit_r + 3'd1;
        if (last_bit) begin
          case (ch_r)
            2'd0:    rgb_r[23:16] <= q_fin;
            2'd1:    rgb_r[15:8]  <= q_fin;
            default: rgb_r[7:0]   <= q_fin;
          endcase
          ch_r <= ch_r + 2'd1;
        end
      end
      crtg_pkg::S_DONE: begin
        out_rgb_r    <= rgb_r;
        out_index_r  <= idx_r;
        out_status_r <= crtg_pkg::ST_OK;
      end
      default: begin
      end
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_red    = out_rgb_r[23:16];
  assign out_green  = out_rgb_r[15:8];
  assign out_blue   = out_rgb_r[7:0];
  assign out_index  = out_index_r;
  assign out_status = out_status_r;

endmodule

FILE: sv/crtg_checker.sv
`timescale 1ns / 1ps
`include "color_ramp_table_generator_macros.svh"

module crtg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_mode,
  input logic        out_valid,
  input logic [7:0]  out_red,
  input logic [7:0]  out_green,
  input logic [7:0]  out_blue,
  input logic [7:0]  out_index,
  input logic [1:0]  out_status
);

  logic edit_beat, ramp_beat, err_beat, colors_zero;

  assign edit_beat   = start && !busy && (in_mode != crtg_pkg::MODE_RAMP);
  assign ramp_beat   = start && !busy && (in_mode == crtg_pkg::MODE_RAMP);
  assign err_beat    = out_valid && (out_status != crtg_pkg::ST_OK);
  assign colors_zero = (out_red == 8'd0) && (out_green == 8'd0) && (out_blue == 8'd0)
                       && (out_index == 8'd0);

  `CRTG_ASSERT_NOW(a_beat_idle, clk, rst_n, out_valid, !busy)
  `CRTG_ASSERT_NEXT(a_edit_beat, clk, rst_n, edit_beat, out_valid)
  `CRTG_ASSERT_NEXT(a_ramp_go, clk, rst_n, ramp_beat, out_valid || busy)
  `CRTG_ASSERT_NOW(a_err_zero, clk, rst_n, err_beat, colors_zero)
  `CRTG_ASSERT_NOW(a_done_beat, clk, rst_n, $fell(busy) && $past(rst_n), out_valid)

endmodule

bind color_ramp_table_generator crtg_checker u_crtg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_mode    (in_mode),
  .out_valid  (out_valid),
  .out_red    (out_red),
  .out_green  (out_green),
  .out_blue   (out_blue),
  .out_index  (out_index),
  .out_status (out_status)
);
